// File: rtl/core/gdiff_command_stream_parser_assert.svh
// ----------------------------------------------------------------------------
// GDIFF command stream parser assertion macros
// Shared property forms for the checker of the command stream parser.
// ----------------------------------------------------------------------------
`ifndef GDIFF_COMMAND_STREAM_PARSER_ASSERT_SVH
`define GDIFF_COMMAND_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GDCSP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GDCSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked during reset.
`define GDCSP_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gdcsp_pkg.sv
// ----------------------------------------------------------------------------
// GDIFF command stream parser package
// Phase and result codes, opcode constants, argument width lookups and the
// result record shared by the parser files.
// ----------------------------------------------------------------------------
package gdcsp_pkg;

  // Parse phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_OPCODE = 3'd1;
  localparam logic [2:0] PH_ARGS   = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  // Result kinds.
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_COPY  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  // Opcodes.
  localparam logic [7:0] OP_EOF          = 8'd0;
  localparam logic [7:0] OP_ADD_MAX      = 8'd246;
  localparam logic [7:0] OP_ADD_L16      = 8'd247;
  localparam logic [7:0] OP_ADD_L32      = 8'd248;
  localparam logic [7:0] OP_COPY_S16_L8  = 8'd249;
  localparam logic [7:0] OP_COPY_S16_L16 = 8'd250;
  localparam logic [7:0] OP_COPY_S16_L32 = 8'd251;
  localparam logic [7:0] OP_COPY_S32_L8  = 8'd252;
  localparam logic [7:0] OP_COPY_S32_L16 = 8'd253;
  localparam logic [7:0] OP_COPY_S32_L32 = 8'd254;

  // One decoded command.
  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] offset;
    logic [31:0] length;
    logic [63:0] total;
  } gdcsp_result_t;

  // Number of length bytes that follow an opcode of 247 or more.
  function automatic logic [3:0] len_bytes(input logic [7:0] op);
    logic [3:0] n;
    case (op)
      OP_ADD_L16:                      n = 4'd2;
      OP_ADD_L32:                      n = 4'd4;
      OP_COPY_S16_L8, OP_COPY_S32_L8:  n = 4'd1;
      OP_COPY_S16_L16, OP_COPY_S32_L16: n = 4'd2;
      default:                         n = 4'd4;
    endcase
    return n;
  endfunction

  // Number of offset bytes that follow a copy opcode.
  function automatic logic [3:0] off_bytes(input logic [7:0] op);
    logic [3:0] n;
    if (op <= OP_ADD_L32) begin
      n = 4'd0;
    end else if (op <= OP_COPY_S16_L32) begin
      n = 4'd2;
    end else if (op <= OP_COPY_S32_L32) begin
      n = 4'd4;
    end else begin
      n = 4'd8;
    end
    return n;
  endfunction

endpackage

// File: rtl/core/gdcsp_stream_if.sv
// ----------------------------------------------------------------------------
// GDIFF command stream parser channels
// Valid/ready channels for patch bytes in and decoded commands out.
// ----------------------------------------------------------------------------
interface gdcsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] patch_byte;
  logic       end_of_file;

  modport source (output valid, output patch_byte, output end_of_file, input ready);
  modport sink   (input valid, input patch_byte, input end_of_file, output ready);
endinterface

interface gdcsp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command_kind;
  logic [63:0] source_offset;
  logic [31:0] command_length;
  logic [63:0] total_length;

  modport source (output valid, output command_kind, output source_offset,
                  output command_length, output total_length, input ready);
  modport sink   (input valid, input command_kind, input source_offset,
                  input command_length, input total_length, output ready);
endinterface

// File: rtl/core/gdcsp_parser.sv
// ----------------------------------------------------------------------------
// GDIFF command stream parser state machine
// Holds the parse state and decodes one patch byte per enabled cycle,
// producing at most one command result for it.
// ----------------------------------------------------------------------------
module gdcsp_parser #(
  parameter int HEADER_BYTES = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic [7:0]              patch_byte,
  input  logic                    end_of_file,
  input  logic                    rel_offsets,
  output logic                    res_vld,
  output gdcsp_pkg::gdcsp_result_t res
);
  import gdcsp_pkg::*;

  localparam int HCW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam logic [HCW:0] HDR_LIMIT = (HCW + 1)'(HEADER_BYTES);
  localparam logic [2:0] PH_RESET = (HEADER_BYTES > 0) ? PH_HEADER : PH_OPCODE;

  logic [2:0]     phase_r, phase_nxt;
  logic [HCW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]     opcode_r, opcode_nxt;
  logic [3:0]     args_r, args_nxt;
  logic [63:0]    off_acc_r, off_acc_nxt;
  logic [31:0]    len_acc_r, len_acc_nxt;
  logic [31:0]    skip_r, skip_nxt;
  logic [63:0]    file_pos_r, file_pos_nxt;
  logic [63:0]    copy_base_r, copy_base_nxt;
  logic [63:0]    total_r, total_nxt;

  logic [31:0]    cmd_len;
  logic           add_total;
  logic [63:0]    sext_off;
  logic [63:0]    copy_sum;

  // Sign extension of the collected copy offset to 64 bits.
  always_comb begin
    case (off_bytes(opcode_r))
      4'd2:    sext_off = {{48{off_acc_nxt[15]}}, off_acc_nxt[15:0]};
      4'd4:    sext_off = {{32{off_acc_nxt[31]}}, off_acc_nxt[31:0]};
      default: sext_off = off_acc_nxt;
    endcase
  end

  assign copy_sum = copy_base_r + sext_off;

  // Running total of command lengths.
  assign total_nxt = add_total ? (total_r + {32'd0, cmd_len}) : total_r;

  // Next-state and result decode for one patch byte.
  always_comb begin
    phase_nxt     = phase_r;
    hdr_cnt_nxt   = hdr_cnt_r;
    opcode_nxt    = opcode_r;
    args_nxt      = args_r;
    off_acc_nxt   = off_acc_r;
    len_acc_nxt   = len_acc_r;
    skip_nxt      = skip_r;
    file_pos_nxt  = file_pos_r + 64'd1;
    copy_base_nxt = copy_base_r;
    cmd_len       = 32'd0;
    add_total     = 1'b0;
    res_vld       = 1'b0;
    res.kind      = KIND_END;
    res.offset    = 64'd0;
    res.length    = 32'd0;

    case (phase_r)
      PH_HEADER: begin
        if (({1'b0, hdr_cnt_r} + 1'b1) >= HDR_LIMIT) begin
          phase_nxt = PH_OPCODE;
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + 1'b1;
        end
        if (end_of_file) begin
          res_vld   = 1'b1;
          phase_nxt = PH_DONE;
        end
      end

      PH_OPCODE: begin
        if (patch_byte == OP_EOF) begin
          res_vld   = 1'b1;
          phase_nxt = PH_DONE;
        end else if (patch_byte <= OP_ADD_MAX) begin
          // Short add: the opcode is the length.
          cmd_len    = {24'd0, patch_byte};
          add_total  = 1'b1;
          skip_nxt   = cmd_len;
          phase_nxt  = end_of_file ? PH_DONE : PH_SKIP;
          res_vld    = 1'b1;
          res.kind   = KIND_ADD;
          res.offset = file_pos_nxt;
          res.length = cmd_len;
        end else begin
          opcode_nxt  = patch_byte;
          args_nxt    = off_bytes(patch_byte) + len_bytes(patch_byte);
          off_acc_nxt = 64'd0;
          len_acc_nxt = 32'd0;
          phase_nxt   = PH_ARGS;
          if (end_of_file) begin
            res_vld   = 1'b1;
            res.kind  = KIND_TRUNC;
            phase_nxt = PH_DONE;
          end
        end
      end

      PH_ARGS: begin
        // Offset bytes come first, then length bytes, both big-endian.
        if (args_r > len_bytes(opcode_r)) begin
          off_acc_nxt = {off_acc_r[55:0], patch_byte};
        end else begin
          len_acc_nxt = {len_acc_r[23:0], patch_byte};
        end
        args_nxt = args_r - 4'd1;
        if (args_nxt == 4'd0) begin
          cmd_len    = len_acc_nxt;
          add_total  = 1'b1;
          res_vld    = 1'b1;
          res.length = cmd_len;
          if (opcode_r <= OP_ADD_L32) begin
            // Long add: skip its data bytes unless it is empty.
            skip_nxt   = cmd_len;
            phase_nxt  = (cmd_len != 32'd0) ? PH_SKIP : PH_OPCODE;
            res.kind   = KIND_ADD;
            res.offset = file_pos_nxt;
          end else begin
            res.kind  = KIND_COPY;
            phase_nxt = PH_OPCODE;
            if (rel_offsets) begin
              copy_base_nxt = copy_sum;
              res.offset    = copy_sum;
            end else begin
              res.offset = off_acc_nxt;
            end
          end
          if (end_of_file) begin
            phase_nxt = PH_DONE;
          end
        end else if (end_of_file) begin
          res_vld   = 1'b1;
          res.kind  = KIND_TRUNC;
          phase_nxt = PH_DONE;
        end
      end

      PH_SKIP: begin
        skip_nxt = skip_r - 32'd1;
        if (skip_nxt == 32'd0) begin
          phase_nxt = PH_OPCODE;
        end
        if (end_of_file) begin
          res_vld   = 1'b1;
          phase_nxt = PH_DONE;
        end
      end

      default: begin
        phase_nxt = PH_DONE;
      end
    endcase

    res.total = total_nxt;
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_RESET;
      hdr_cnt_r   <= '0;
      opcode_r    <= 8'd0;
      args_r      <= 4'd0;
      off_acc_r   <= 64'd0;
      len_acc_r   <= 32'd0;
      skip_r      <= 32'd0;
      file_pos_r  <= 64'd0;
      copy_base_r <= 64'd0;
      total_r     <= 64'd0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      opcode_r    <= opcode_nxt;
      args_r      <= args_nxt;
      off_acc_r   <= off_acc_nxt;
      len_acc_r   <= len_acc_nxt;
      skip_r      <= skip_nxt;
      file_pos_r  <= file_pos_nxt;
      copy_base_r <= copy_base_nxt;
      total_r     <= total_nxt;
    end
  end

endmodule

// File: rtl/core/gdiff_command_stream_parser.sv
// ----------------------------------------------------------------------------
// GDIFF command stream parser
// Decodes a GDIFF patch byte stream into add, copy, end and truncation commands.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one patch byte per beat, with end_of_file set on the last
//   byte of the file. The first HEADER_BYTES bytes are skipped unchecked.
//   out_if carries one decoded command per beat: kind, source offset,
//   length and the running total of all command lengths.
//   cfg_wr_en/cfg_wr_data write the relative-offset mode bit; write it only
//   while no byte is in flight.
//   Throughput is one byte per cycle while the receiver does not stall: a
//   byte is registered, decoded by the parser once the output register can
//   take a result, and its command then lands in the output register.
//   Most bytes (header, arguments, add data) yield no output beat.
//   When the receiver stalls, the output register holds its beat and the
//   input register holds one more byte; in_if.ready drops only when both
//   are full. After an end, truncation or end-of-file, bytes are still
//   accepted and ignored until reset.
//   Reset (rst_n low, synchronous) clears all parse state, the mode bit
//   and both valid flags.
// ----------------------------------------------------------------------------
module gdiff_command_stream_parser #(
  parameter int HEADER_BYTES = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  gdcsp_in_if.sink   in_if,
  gdcsp_out_if.source out_if
);
  import gdcsp_pkg::*;

  logic          rel_r;
  logic          in_vld_r;
  logic [7:0]    in_byte_r;
  logic          in_eof_r;
  logic          advance;
  logic          res_vld;
  gdcsp_result_t res;
  logic          out_vld_r;
  gdcsp_result_t out_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r <= 1'b0;
    end else if (cfg_wr_en) begin
      rel_r <= cfg_wr_data;
    end
  end

  // A held byte is decoded once the output register can take a result.
  assign advance     = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_r <= in_if.patch_byte;
      in_eof_r  <= in_if.end_of_file;
    end
  end

  // Decode state machine.
  gdcsp_parser #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .patch_byte  (in_byte_r),
    .end_of_file (in_eof_r),
    .rel_offsets (rel_r),
    .res_vld     (res_vld),
    .res         (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res_vld) begin
      out_vld_r <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_vld) begin
      out_r <= res;
    end
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.command_kind   = out_r.kind;
  assign out_if.source_offset  = out_r.offset;
  assign out_if.command_length = out_r.length;
  assign out_if.total_length   = out_r.total;

endmodule

// File: rtl/core/gdcsp_checker.sv
// ----------------------------------------------------------------------------
// GDIFF command stream parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "gdiff_command_stream_parser_assert.svh"

module gdcsp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind
);
  import gdcsp_pkg::*;

  logic stopped_r;

  // Set once an end or truncation beat has been delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= 1'b0;
    end else if (out_valid && out_ready &&
                 (out_kind == KIND_END || out_kind == KIND_TRUNC)) begin
      stopped_r <= 1'b1;
    end
  end

  `GDCSP_ASSERT_NEXT_ALWAYS(a_reset_clears_out, !rst_n, !out_valid, "output valid after reset")
  `GDCSP_ASSERT_IMPLY(a_silent_after_stop, stopped_r, !out_valid, "beat after end of stream")
  `GDCSP_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "stalled beat dropped")
  `GDCSP_ASSERT_NEXT(a_kind_held, out_valid && !out_ready, $stable(out_kind), "stalled kind changed")

endmodule

bind gdiff_command_stream_parser gdcsp_checker u_gdcsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_kind  (out_if.command_kind)
);

// File: sim/gdiff_command_stream_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GDIFF command stream parser testbench
// Feeds one patch stream through the parser: header bytes, add and copy
// opcodes, copies in absolute and relative mode and one randomly chosen
// way of ending the file. Each command beat is checked field by field
// against a byte-level decoder kept in step with the accepted input beats.
// ----------------------------------------------------------------------------
module gdiff_command_stream_parser_test;
  import gdcsp_pkg::*;

  localparam int         HDR_LEN         = 5;
  localparam int         CLK_PERIOD      = 8;
  localparam int         ITEM_TARGET     = 700;
  localparam int         STALL_LIMIT     = 2000;
  localparam int         DRAIN_CYCLES    = 4;
  localparam logic [7:0] OP_COPY_S64_L32 = 8'd255;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  gdcsp_in_if  byte_ch ();
  gdcsp_out_if cmd_ch ();

  gdiff_command_stream_parser #(.HEADER_BYTES(HDR_LEN)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_if       (byte_ch),
    .out_if      (cmd_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Decoder state that mirrors the parser.
  logic        relative_mode;
  logic [2:0]  parse_phase;
  int          hdr_seen;
  logic [7:0]  op_latched;
  int          args_left;
  logic [63:0] off_shift;
  logic [31:0] len_shift;
  logic [31:0] data_left;
  logic [63:0] byte_pos;
  logic [63:0] copy_anchor;
  logic [63:0] running_total;

  gdcsp_result_t pending_cmds[$];

  // Bookkeeping for the checker, the watchdog and the closing summary.
  int failures;
  int kinds_seen[4];
  int patch_bytes;
  int mode_writes;
  int quiet_cycles;
  int stall_left;
  bit idling_on;

  // Offset and length field widths in bytes; zero for plain adds and the end.
  function automatic void field_widths(input logic [7:0] op, output int off_w,
                                       output int len_w);
    off_w = 0;
    len_w = 0;
    case (op)
      OP_ADD_L16:      len_w = 2;
      OP_ADD_L32:      len_w = 4;
      OP_COPY_S16_L8:  begin off_w = 2; len_w = 1; end
      OP_COPY_S16_L16: begin off_w = 2; len_w = 2; end
      OP_COPY_S16_L32: begin off_w = 2; len_w = 4; end
      OP_COPY_S32_L8:  begin off_w = 4; len_w = 1; end
      OP_COPY_S32_L16: begin off_w = 4; len_w = 2; end
      OP_COPY_S32_L32: begin off_w = 4; len_w = 4; end
      OP_COPY_S64_L32: begin off_w = 8; len_w = 4; end
      default: ;
    endcase
  endfunction

  function automatic void push_command(input logic [1:0] kind, input logic [63:0] off,
                                       input logic [31:0] len);
    gdcsp_result_t cmd;
    cmd.kind   = kind;
    cmd.offset = off;
    cmd.length = len;
    cmd.total  = running_total;
    pending_cmds.push_back(cmd);
  endfunction

  // An add reports where its data starts, then its data bytes are skipped.
  function automatic void open_add(input logic [31:0] len);
    running_total += 64'(len);
    data_left = len;
    parse_phase = (len != 0) ? PH_SKIP : PH_OPCODE;
    push_command(KIND_ADD, byte_pos, len);
  endfunction

  // Advances the decoder by one accepted patch byte.
  function automatic void decode_patch_byte(input logic [7:0] b, input logic eof);
    int off_w;
    int len_w;
    logic [63:0] off;
    byte_pos += 1;
    case (parse_phase)
      PH_HEADER: begin
        if (hdr_seen + 1 >= HDR_LEN) parse_phase = PH_OPCODE;
        else hdr_seen++;
        if (eof) begin
          push_command(KIND_END, '0, '0);
          parse_phase = PH_DONE;
        end
      end
      PH_OPCODE: begin
        if (b == OP_EOF) begin
          push_command(KIND_END, '0, '0);
          parse_phase = PH_DONE;
        end else if (b <= OP_ADD_MAX) begin
          open_add(32'(b));
          if (eof) parse_phase = PH_DONE;
        end else begin
          field_widths(b, off_w, len_w);
          op_latched  = b;
          args_left   = off_w + len_w;
          off_shift   = '0;
          len_shift   = '0;
          parse_phase = PH_ARGS;
          if (eof) begin
            push_command(KIND_TRUNC, '0, '0);
            parse_phase = PH_DONE;
          end
        end
      end
      PH_ARGS: begin
        field_widths(op_latched, off_w, len_w);
        if (args_left > len_w) off_shift = {off_shift[55:0], b};
        else len_shift = {len_shift[23:0], b};
        args_left--;
        if (args_left == 0) begin
          if (op_latched <= OP_ADD_L32) begin
            open_add(len_shift);
          end else begin
            off = off_shift;
            // Relative offsets are signed at their own width.
            if (relative_mode) begin
              if (off_w == 2) off = {{48{off_shift[15]}}, off_shift[15:0]};
              else if (off_w == 4) off = {{32{off_shift[31]}}, off_shift[31:0]};
              copy_anchor += off;
              off = copy_anchor;
            end
            running_total += 64'(len_shift);
            push_command(KIND_COPY, off, len_shift);
            parse_phase = PH_OPCODE;
          end
          if (eof) parse_phase = PH_DONE;
        end else if (eof) begin
          push_command(KIND_TRUNC, '0, '0);
          parse_phase = PH_DONE;
        end
      end
      PH_SKIP: begin
        data_left -= 1;
        if (data_left == 0) parse_phase = PH_OPCODE;
        if (eof) begin
          push_command(KIND_END, '0, '0);
          parse_phase = PH_DONE;
        end
      end
      default: parse_phase = PH_DONE;
    endcase
  endfunction

  // Result side: random stall bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      cmd_ch.ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      cmd_ch.ready <= 1'b1;
    end
  end

  // Compare each command beat with the oldest pending expectation.
  always @(posedge clk) begin
    gdcsp_result_t want;
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected command beat: kind %0d offset %0h length %0h",
               cmd_ch.command_kind, cmd_ch.source_offset, cmd_ch.command_length);
        failures++;
      end else begin
        want = pending_cmds.pop_front();
        kinds_seen[want.kind]++;
        if (cmd_ch.command_kind !== want.kind) begin
          $error("command_kind: expected %0d, got %0d", want.kind, cmd_ch.command_kind);
          failures++;
        end
        if (cmd_ch.source_offset !== want.offset) begin
          $error("source_offset: expected %0h, got %0h", want.offset, cmd_ch.source_offset);
          failures++;
        end
        if (cmd_ch.command_length !== want.length) begin
          $error("command_length: expected %0h, got %0h", want.length,
                 cmd_ch.command_length);
          failures++;
        end
        if (cmd_ch.total_length !== want.total) begin
          $error("total_length: expected %0h, got %0h", want.total, cmd_ch.total_length);
          failures++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("gdiff_command_stream_parser regression: fail");
      $finish;
    end
  end

  // Sends one patch byte; called and returning at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.patch_byte  <= b;
    byte_ch.end_of_file <= eof;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    decode_patch_byte(b, eof);
    patch_bytes++;
    @(negedge clk);
  endtask

  // Sends one command big-endian. A nonzero cut stops after that many bytes
  // and marks the last one sent as the end of the file.
  task automatic send_command(input logic [7:0] op, input logic [63:0] off_val,
                              input logic [31:0] len_val, input int cut);
    logic [7:0] cmd_bytes[$];
    int off_w;
    int len_w;
    int data_n;
    int n;
    field_widths(op, off_w, len_w);
    cmd_bytes.push_back(op);
    for (int i = off_w - 1; i >= 0; i--) cmd_bytes.push_back(off_val[8 * i +: 8]);
    for (int i = len_w - 1; i >= 0; i--) cmd_bytes.push_back(len_val[8 * i +: 8]);
    if (op == OP_EOF || op > OP_ADD_L32) data_n = 0;
    else if (op <= OP_ADD_MAX) data_n = op;
    else data_n = len_val;
    repeat (data_n) cmd_bytes.push_back(8'($urandom_range(0, 255)));
    n = (cut > 0 && cut < cmd_bytes.size()) ? cut : cmd_bytes.size();
    for (int i = 0; i < n; i++) send_byte(cmd_bytes[i], cut > 0 && i == n - 1);
  endtask

  // Mostly short adds and copies with random fields; adds with a length
  // field stay short so their data does not swamp the stream.
  task automatic send_random_command();
    logic [7:0]  op;
    logic [63:0] off_val;
    logic [31:0] len_val;
    int pick;
    pick    = $urandom_range(0, 9);
    off_val = {$urandom, $urandom};
    len_val = $urandom;
    if (pick < 4) begin
      if ($urandom_range(0, 24) == 0) op = 8'($urandom_range(9, OP_ADD_MAX));
      else op = 8'($urandom_range(1, 8));
    end else if (pick == 4) begin
      op      = $urandom_range(0, 1) ? OP_ADD_L16 : OP_ADD_L32;
      len_val = $urandom_range(0, 12);
    end else begin
      op = 8'($urandom_range(OP_COPY_S16_L8, OP_COPY_S64_L32));
      case ($urandom_range(0, 5))
        0: off_val = '1;
        1: off_val = '0;
        2: len_val = '1;
        3: len_val = '0;
        default: ;
      endcase
    end
    send_command(op, off_val, len_val, 0);
  endtask

  // Waits until every expected command is out and the pipeline is empty.
  task automatic drain();
    byte_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic rel);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rel;
    @(negedge clk);
    cfg_wr_en     <= 1'b0;
    relative_mode = rel;
    mode_writes++;
  endtask

  // Header bytes are skipped whatever they hold.
  task automatic test_header();
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    repeat (HDR_LEN - 2) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Absolute mode: shortest add, zero-length add, widest copy at its extremes, narrowest copy at zero.
  task automatic test_absolute_commands();
    send_command(8'd1, '0, '0, 0);
    send_command(OP_ADD_L16, '0, 32'd0, 0);
    send_command(OP_COPY_S64_L32, '1, '1, 0);
    send_command(OP_COPY_S16_L8, '0, '0, 0);
  endtask

  // Relative mode: sign extension at each offset width and 64-bit wrap.
  task automatic test_relative_copies();
    drain();
    write_mode(1'b1);
    send_command(OP_COPY_S16_L8, 64'h8000, 32'd1, 0);
    send_command(OP_COPY_S32_L16, 64'h7fff_ffff, 32'hffff, 0);
    send_command(OP_COPY_S32_L8, 64'hffff_ffff, 32'd0, 0);
    send_command(OP_COPY_S64_L32, 64'h8000_0000_0000_0000, 32'h8000_0000, 0);
    repeat (3) send_random_command();
  endtask

  // Random commands in phases; each phase picks the mode and whether both
  // sides idle, and the sender holds off until all commands are out.
  task automatic test_random_phases();
    int phase_end;
    for (int p = 0; p < 4; p++) begin
      drain();
      if (p < 2) write_mode(p[0]);
      else write_mode(1'($urandom_range(0, 1)));
      idling_on = (p == 0) || ($urandom_range(0, 3) != 0);
      phase_end = patch_bytes + (ITEM_TARGET - 160) / 4;
      if (p == 1) send_command(OP_ADD_MAX, '0, '0, 0);
      while (patch_bytes < phase_end) send_random_command();
    end
  endtask

  // Without idling: a few commands, then one way of ending the file picked
  // at random, then bytes that the stopped parser must ignore.
  task automatic test_stream_end();
    logic [7:0]  op;
    logic [31:0] len_val;
    int off_w;
    int len_w;
    int cut;
    drain();
    idling_on = 0;
    write_mode(1'($urandom_range(0, 1)));
    repeat (8) send_random_command();
    op  = 8'($urandom_range(OP_ADD_L16, OP_COPY_S64_L32));
    field_widths(op, off_w, len_w);
    len_val = (op > OP_ADD_L32) ? 32'($urandom) : 32'($urandom_range(0, 12));
    case ($urandom_range(0, 7))
      // End opcode, with or without the end-of-file flag.
      0: send_command(OP_EOF, '0, '0, $urandom_range(0, 1));
      // End of file on the last data byte of an add.
      1: begin
        op = 8'($urandom_range(1, 16));
        send_command(op, '0, '0, op + 1);
      end
      // End of file inside add data.
      2: begin
        op = 8'($urandom_range(2, 16));
        send_command(op, '0, '0, $urandom_range(2, op));
      end
      // End of file on the byte that completes a copy.
      3: begin
        op = 8'($urandom_range(OP_COPY_S16_L8, OP_COPY_S64_L32));
        field_widths(op, off_w, len_w);
        send_command(op, {$urandom, $urandom}, $urandom, 1 + off_w + len_w);
      end
      // End of file before all argument bytes arrived.
      4: send_command(op, {$urandom, $urandom}, len_val, $urandom_range(2, off_w + len_w));
      // End of file on an opcode that still needs arguments.
      5: send_command(op, {$urandom, $urandom}, len_val, 1);
      // End of file on the opcode of a plain add.
      6: send_command(8'($urandom_range(1, OP_ADD_MAX)), '0, '0, 1);
      // Zero-length add that ends the file.
      default: send_command(OP_ADD_L16, '0, 32'd0, 3);
    endcase
    repeat (5) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = 1'b0;
    byte_ch.valid       = 1'b0;
    byte_ch.patch_byte  = 8'h00;
    byte_ch.end_of_file = 1'b0;
    cmd_ch.ready        = 1'b0;
    idling_on           = 1;
    stall_left          = 0;
    quiet_cycles        = 0;
    failures            = 0;
    patch_bytes         = 0;
    mode_writes         = 0;
    relative_mode       = 1'b0;
    parse_phase         = (HDR_LEN > 0) ? PH_HEADER : PH_OPCODE;
    hdr_seen            = 0;
    op_latched          = '0;
    args_left           = 0;
    off_shift           = '0;
    len_shift           = '0;
    data_left           = '0;
    byte_pos            = '0;
    copy_anchor         = '0;
    running_total       = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_mode(1'b0);
    test_header();
    test_absolute_commands();
    test_relative_copies();
    test_random_phases();
    test_stream_end();

    drain();
    repeat (8) @(negedge clk);
    $display("Covered %0d patch bytes across %0d mode writes: %0d adds, %0d copies,",
             patch_bytes, mode_writes, kinds_seen[KIND_ADD], kinds_seen[KIND_COPY]);
    $display("%0d end and %0d truncation reports, %0d mismatches.",
             kinds_seen[KIND_END], kinds_seen[KIND_TRUNC], failures);
    if (failures == 0) begin
      $display("gdiff_command_stream_parser regression: pass");
    end else begin
      $display("gdiff_command_stream_parser regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/gdcsp_pkg.sv
rtl/core/gdcsp_stream_if.sv
rtl/core/gdcsp_parser.sv
rtl/core/gdiff_command_stream_parser.sv
rtl/core/gdcsp_checker.sv
sim/gdiff_command_stream_parser_test.sv
